// File: rtl/rs16_pkg.sv
// Shared types, opcode codes and register file reset values for the execute block.
package rs16_pkg;

	localparam int unsigned NUM_REGS  = 8;
	localparam int unsigned REG_W     = 16;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned INSTR_W   = 16;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_ADDI = 3'd1;
	localparam logic [2:0] OP_NAND = 3'd2;
	localparam logic [2:0] OP_LUI  = 3'd3;

	localparam logic [3:0] ADD_PAD_ZERO = 4'b0000;

	typedef logic [REG_W-1:0] word_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic  wrote;
		idx_t  dest_index;
		word_t dest_value;
	} res_t;

	// Register contents right after reset.
	function automatic word_t reset_value(input idx_t idx);
		word_t v;
		case (idx)
			3'd0: v = 16'hE001;
			3'd1: v = 16'h2900;
			3'd2: v = 16'h21C0;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/rs16_in_if.sv
// Instruction channel: valid/ready handshake carrying one instruction word.
interface rs16_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] instr_word;

	modport source (output valid, output instr_word, input ready);
	modport sink   (input valid, input instr_word, output ready);
endinterface

// File: rtl/rs16_out_if.sv
// Result channel: valid/ready handshake carrying one write-back record.
interface rs16_out_if;
	logic        valid;
	logic        ready;
	logic        wrote;
	logic [2:0]  dest_index;
	logic [15:0] dest_value;

	modport source (output valid, output wrote, output dest_index, output dest_value,
		input ready);
	modport sink   (input valid, input wrote, input dest_index, input dest_value,
		output ready);
endinterface

// File: rtl/rs16_ram.sv
// Generic RAM with one write port and two registered read ports.
module rs16_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     ren,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// File: rtl/rs16_alu.sv
// Decode and execute of one instruction from its two operand values.
module rs16_alu
	import rs16_pkg::*;
(
	input  logic [INSTR_W-1:0] instr,
	input  word_t              op_a,
	input  word_t              op_b,
	output res_t               res
);

	logic [2:0] opc;
	idx_t       dst;
	word_t      val;
	logic       wr;

	assign opc = instr[15:13];
	assign dst = instr[12:10];

	always_comb begin
		val = '0;
		wr  = 1'b0;
		case (opc)
			OP_ADD: begin
				if (instr[6:3] == ADD_PAD_ZERO) begin
					val = op_a + op_b;
					wr  = 1'b1;
				end
			end
			OP_ADDI: begin
				val = op_a + {9'd0, instr[6:0]};
				wr  = 1'b1;
			end
			OP_NAND: begin
				val = ~(op_a & op_b);
				wr  = 1'b1;
			end
			OP_LUI: begin
				val = {instr[9:0], 6'd0};
				wr  = 1'b1;
			end
			default: begin
				val = '0;
				wr  = 1'b0;
			end
		endcase
	end

	always_comb begin
		res.wrote      = wr;
		res.dest_index = wr ? dst : '0;
		res.dest_value = wr ? val : '0;
	end

endmodule

// File: rtl/risc16_subset_execute.sv
// Top level of the 16-bit subset execute block: register file, execute stage, result register.
//
//   channel   dir   payload                              handshake
//   instr     in    instr_word[15:0]                     instr.valid && instr.ready
//   result    out   wrote, dest_index[2:0], dest_value   result.valid && result.ready
//
// Every instruction gives exactly one result item, registered first in the execute
// stage and then in the result register; one item per clock is sustained when the
// result side is ready. The register file sits in a small RAM whose reads are
// registered at acceptance, so that read port feeds the execute stage.
// Reset clears the pipeline valids and the per-register written flags; a register
// never written since reset reads as its reset value, so no clearing pass is needed.
// A stall on the result side holds the result register, then the execute stage,
// then drops instr.ready; a new item is accepted whenever the stage ahead moves on.
module risc16_subset_execute
	import rs16_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rs16_in_if.sink    instr,
	rs16_out_if.source result
);

	// Execute stage.
	logic                v_s1;
	logic [INSTR_W-1:0]  instr_s1;
	logic                vld_a_s1;
	logic                vld_b_s1;

	// The write-back that happened at the same edge the current stage item read the RAM.
	// The RAM returns the old contents for that edge, so it is forwarded here.
	logic                fresh_q;
	idx_t                wb_idx_q;
	word_t               wb_val_q;

	// Written flags: a clear flag means the register still holds its reset value.
	logic [NUM_REGS-1:0] written_q;

	// Result register.
	logic                out_valid_q;
	res_t                res_q;

	logic  advance;
	logic  accept;
	logic  fire;
	logic  wr_en;
	idx_t  rd_a_idx;
	idx_t  rd_b_idx;
	idx_t  sa_s1;
	idx_t  sb_s1;
	word_t ram_a;
	word_t ram_b;
	word_t op_a;
	word_t op_b;
	res_t  res;

	// The stage moves on when the result register is empty or being drained.
	assign advance     = !out_valid_q || result.ready;
	assign instr.ready = !v_s1 || advance;
	assign accept      = instr.valid && instr.ready;
	assign fire        = v_s1 && advance;
	assign wr_en       = fire && res.wrote;

	assign rd_a_idx = instr.instr_word[9:7];
	assign rd_b_idx = instr.instr_word[2:0];
	assign sa_s1    = instr_s1[9:7];
	assign sb_s1    = instr_s1[2:0];

	rs16_ram #(
		.WIDTH (REG_W),
		.DEPTH (NUM_REGS)
	) u_regs (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (res.dest_index),
		.wdata   (res.dest_value),
		.ren     (accept),
		.raddr_a (rd_a_idx),
		.raddr_b (rd_b_idx),
		.rdata_a (ram_a),
		.rdata_b (ram_b)
	);

	// Operand select: forwarded write, then RAM contents, then the reset value.
	always_comb begin
		if (fresh_q && wb_idx_q == sa_s1) begin
			op_a = wb_val_q;
		end else if (vld_a_s1) begin
			op_a = ram_a;
		end else begin
			op_a = reset_value(sa_s1);
		end
		if (fresh_q && wb_idx_q == sb_s1) begin
			op_b = wb_val_q;
		end else if (vld_b_s1) begin
			op_b = ram_b;
		end else begin
			op_b = reset_value(sb_s1);
		end
	end

	rs16_alu u_alu (
		.instr (instr_s1),
		.op_a  (op_a),
		.op_b  (op_b),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			written_q   <= '0;
			fresh_q     <= 1'b0;
		end else begin
			if (accept) begin
				v_s1    <= 1'b1;
				fresh_q <= wr_en;
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				written_q[res.dest_index] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instr.instr_word;
			vld_a_s1 <= written_q[rd_a_idx];
			vld_b_s1 <= written_q[rd_b_idx];
			wb_idx_q <= res.dest_index;
			wb_val_q <= res.dest_value;
		end
		if (fire) begin
			res_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.wrote      = res_q.wrote;
	assign result.dest_index = res_q.dest_index;
	assign result.dest_value = res_q.dest_value;

endmodule

// File: tb/risc16_subset_execute_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the write-back item of every accepted instruction and compares results.
module risc16_subset_execute_checker
	import rs16_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	rs16_in_if   instr_ch,
	rs16_out_if  result_ch,
	output int   mismatch_count,
	output int   writebacks_pending
);

	localparam word_t R0_AT_RESET = 16'hE001;
	localparam word_t R1_AT_RESET = 16'h2900;
	localparam word_t R2_AT_RESET = 16'h21C0;

	word_t shadow_regs [NUM_REGS];
	res_t  expected_writebacks [$];

	// Executes one instruction on the shadow register file and returns its write-back.
	// Sources are read before the destination is updated.
	function automatic res_t execute_instr(input logic [INSTR_W-1:0] w);
		logic [2:0] opc;
		idx_t       dst;
		word_t      va;
		word_t      vb;
		res_t       r;
		opc = w[15:13];
		dst = w[12:10];
		va  = shadow_regs[w[9:7]];
		vb  = shadow_regs[w[2:0]];
		r   = '0;
		case (opc)
			OP_ADD: begin
				if (w[6:3] == ADD_PAD_ZERO) begin
					r.wrote      = 1'b1;
					r.dest_value = va + vb;
				end
			end
			OP_ADDI: begin
				r.wrote      = 1'b1;
				r.dest_value = va + {9'd0, w[6:0]};
			end
			OP_NAND: begin
				r.wrote      = 1'b1;
				r.dest_value = ~(va & vb);
			end
			OP_LUI: begin
				r.wrote      = 1'b1;
				r.dest_value = {w[9:0], 6'd0};
			end
			default: begin
			end
		endcase
		if (r.wrote) begin
			r.dest_index     = dst;
			shadow_regs[dst] = r.dest_value;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			foreach (shadow_regs[i])
				shadow_regs[i] = '0;
			shadow_regs[0] = R0_AT_RESET;
			shadow_regs[1] = R1_AT_RESET;
			shadow_regs[2] = R2_AT_RESET;
			expected_writebacks.delete();
			writebacks_pending = 0;
			mismatch_count     = 0;
		end else begin
			// Retire first, so a stray result never pairs with an item accepted this edge.
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.wrote, result_ch.dest_index, result_ch.dest_value};
				if (expected_writebacks.size() == 0) begin
					$error("result item with no instruction outstanding: wrote %b index %0d value %h",
						got.wrote, got.dest_index, got.dest_value);
					mismatch_count++;
				end else begin
					want = expected_writebacks.pop_front();
					if (got.wrote !== want.wrote) begin
						$error("wrote: expected %b, actual %b", want.wrote, got.wrote);
						mismatch_count++;
					end
					if (got.dest_index !== want.dest_index) begin
						$error("dest_index: expected %0d, actual %0d",
							want.dest_index, got.dest_index);
						mismatch_count++;
					end
					if (got.dest_value !== want.dest_value) begin
						$error("dest_value: expected %h, actual %h",
							want.dest_value, got.dest_value);
						mismatch_count++;
					end
				end
			end
			if (instr_ch.valid && instr_ch.ready)
				expected_writebacks.push_back(execute_instr(instr_ch.instr_word));
			writebacks_pending = expected_writebacks.size();
		end
	end

endmodule

// File: tb/risc16_subset_execute_test.sv
`timescale 1ns / 100ps
// Top of the execute block testbench: clock, reset, instruction stimulus, result stalls, verdict.
module risc16_subset_execute_test;
	import rs16_pkg::*;

	// Opcodes that the block treats as no operation.
	localparam logic [2:0] OP_NONE_FIRST = 3'd4;
	localparam logic [2:0] OP_NONE_LAST  = 3'd7;

	// Number of random instructions after the directed part.
	localparam int RANDOM_ITEMS = 1630;
	// The result side holds off once; HOLD_START sets its start after reset, HOLD_CYCLES its length.
	localparam int HOLD_START  = 400;
	localparam int HOLD_CYCLES = 150;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatch_count;
	int   writebacks_pending;

	rs16_in_if  instr_ch ();
	rs16_out_if result_ch ();

	risc16_subset_execute u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	risc16_subset_execute_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.instr_ch           (instr_ch),
		.result_ch          (result_ch),
		.mismatch_count     (mismatch_count),
		.writebacks_pending (writebacks_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Assembles an instruction word from its fields. The low seven bits hold either
	// the add padding and second source, or the immediate.
	function automatic logic [INSTR_W-1:0] encode(input logic [2:0] op, input idx_t dst,
		input idx_t src_a, input logic [6:0] low);
		return {op, dst, src_a, low};
	endfunction

	// Draws one random instruction. Most are well-formed writes with random registers
	// and immediates; the rest are adds with a nonzero pad and the unused opcodes.
	function automatic logic [INSTR_W-1:0] random_instr();
		int         pick;
		logic [6:0] low;
		pick = $urandom_range(0, 99);
		low  = 7'($urandom);
		if (pick < 25)
			return encode(OP_ADD, 3'($urandom), 3'($urandom), {ADD_PAD_ZERO, low[2:0]});
		else if (pick < 45)
			return encode(OP_ADDI, 3'($urandom), 3'($urandom), low);
		else if (pick < 65)
			return encode(OP_NAND, 3'($urandom), 3'($urandom), low);
		else if (pick < 80)
			return encode(OP_LUI, 3'($urandom), 3'($urandom), low);
		else if (pick < 90) begin
			// Force at least one pad bit high so the add is dropped.
			if (low[6:3] == ADD_PAD_ZERO)
				low[3 + $urandom_range(0, 3)] = 1'b1;
			return encode(OP_ADD, 3'($urandom), 3'($urandom), low);
		end else
			return encode(3'($urandom_range(OP_NONE_FIRST, OP_NONE_LAST)),
				3'($urandom), 3'($urandom), low);
	endfunction

	// Offers one item from a falling edge and returns at the falling edge after it
	// is taken. Valid stays high, so a following call continues the burst.
	task automatic send_item(input logic [INSTR_W-1:0] w);
		instr_ch.valid      <= 1'b1;
		instr_ch.instr_word <= w;
		do
			@(posedge clk);
		while (!instr_ch.ready);
		@(negedge clk);
	endtask

	// Drops valid for a number of cycles; a zero gap keeps the burst going.
	// The payload takes a random value while idle since the block must ignore it.
	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			instr_ch.valid      <= 1'b0;
			instr_ch.instr_word <= 16'($urandom);
			repeat (cycles) @(negedge clk);
		end
	endtask

	// Holds the input idle until every accepted item has come back.
	task automatic wait_drained();
		instr_ch.valid <= 1'b0;
		@(negedge clk);
		while (writebacks_pending != 0)
			@(negedge clk);
	endtask

	// Picks the idle time after an item: mostly inside a burst, so no gap, and at
	// the end of a burst a random gap.
	task automatic pace(inout int burst_left);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle_for(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
			burst_left = $urandom_range(1, 40);
		end
	endtask

	// Instruction side: reset, then a short directed list, then random items.
	initial begin
		logic [INSTR_W-1:0] directed [$];
		int                 burst_left;
		arst_n              <= 1'b0;
		instr_ch.valid      <= 1'b0;
		instr_ch.instr_word <= '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The first adds read registers never written since reset, and the first
		// one wraps past bit 15.
		directed.push_back(encode(OP_ADD, 3'd3, 3'd0, {ADD_PAD_ZERO, 3'd1}));
		directed.push_back(encode(OP_ADD, 3'd4, 3'd2, {ADD_PAD_ZERO, 3'd2}));
		// Same register as both sources and destination.
		directed.push_back(encode(OP_ADD, 3'd0, 3'd0, {ADD_PAD_ZERO, 3'd0}));
		// Adds with pad bits set must write nothing.
		directed.push_back(encode(OP_ADD, 3'd5, 3'd1, {~ADD_PAD_ZERO, 3'd1}));
		directed.push_back(encode(OP_ADD, 3'd5, 3'd1, {4'b1000, 3'd1}));
		directed.push_back(encode(OP_ADD, 3'd6, 3'd2, {4'b0001, 3'd3}));
		// Immediate extremes.
		directed.push_back(encode(OP_ADDI, 3'd7, 3'd7, 7'h7F));
		directed.push_back(encode(OP_ADDI, 3'd6, 3'd1, 7'h00));
		// The largest upper immediate, then an add of the largest small immediate
		// that carries out of bit 15.
		directed.push_back(encode(OP_LUI, 3'd1, 3'd7, 7'h7F));
		directed.push_back(encode(OP_ADDI, 3'd1, 3'd1, 7'h7F));
		directed.push_back(encode(OP_LUI, 3'd2, 3'd0, 7'h00));
		// Nand ignores bits 6:3, whatever they hold.
		directed.push_back(encode(OP_NAND, 3'd3, 3'd1, {ADD_PAD_ZERO, 3'd1}));
		directed.push_back(encode(OP_NAND, 3'd0, 3'd2, {4'b1111, 3'd6}));
		directed.push_back(encode(OP_NAND, 3'd7, 3'd0, {4'b0101, 3'd7}));
		// Every unused opcode, one with all other bits high.
		for (int op = OP_NONE_FIRST; op < OP_NONE_LAST; op++)
			directed.push_back(encode(op[2:0], 3'($urandom), 3'($urandom), 7'($urandom)));
		directed.push_back(16'hFFFF);
		// All-ones register doubled: carry dropped.
		directed.push_back(encode(OP_LUI, 3'd7, 3'd7, 7'h7F));
		directed.push_back(encode(OP_ADDI, 3'd7, 3'd7, 7'h3F));
		directed.push_back(encode(OP_ADD, 3'd7, 3'd7, {ADD_PAD_ZERO, 3'd7}));
		directed.push_back(16'h0000);
		directed.push_back(encode(OP_ADDI, 3'd0, 3'd0, 7'h01));

		burst_left = 0;
		foreach (directed[i]) begin
			send_item(directed[i]);
			pace(burst_left);
		end

		// Random part. Twice the sender stops until every result is back, clear of
		// the long hold-off on the result side.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 700 || i == 1300)
				wait_drained();
			send_item(random_instr());
			pace(burst_left);
		end

		wait_drained();
		// A few cycles more catch any stray item after the last one.
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("risc16_subset_execute test passed");
		else
			$display("risc16_subset_execute test failed");
		$finish;
	end

	// Result side: segments of always-ready, coin-flip and mostly-ready behavior,
	// and one long hold-off while the sender keeps offering, which fills the
	// pipeline and must drop instr.ready.
	initial begin
		int mode;
		int seg_len;
		int cycle_count;
		bit held;
		result_ch.ready <= 1'b0;
		cycle_count = 0;
		held        = 1'b0;
		@(posedge arst_n);
		forever begin
			mode    = $urandom_range(0, 2);
			seg_len = $urandom_range(10, 60);
			repeat (seg_len) begin
				@(negedge clk);
				cycle_count++;
				if (!held && cycle_count >= HOLD_START) begin
					held = 1'b1;
					result_ch.ready <= 1'b0;
					repeat (HOLD_CYCLES - 1) @(negedge clk);
					cycle_count += HOLD_CYCLES - 1;
				end else begin
					case (mode)
						0: result_ch.ready <= 1'b1;
						1: result_ch.ready <= 1'($urandom_range(0, 1));
						default: result_ch.ready <= ($urandom_range(0, 7) != 0);
					endcase
				end
			end
		end
	end

	// The slowest correct run finishes well before this watchdog fails the run.
	initial begin
		#2000000;
		$display("risc16_subset_execute test failed");
		$finish;
	end

endmodule

// File: files.f
rtl/rs16_pkg.sv
rtl/rs16_in_if.sv
rtl/rs16_out_if.sv
rtl/rs16_ram.sv
rtl/rs16_alu.sv
rtl/risc16_subset_execute.sv
tb/risc16_subset_execute_checker.sv
tb/risc16_subset_execute_test.sv
